// File: hdl/mlfd_pkg.sv
// Shared types and constants of the magic-length frame deframer.
package mlfd_pkg;

    // Default frame geometry.
    localparam int HEADER_BYTES_DEF = 12;
    localparam int FRAME_BYTES_DEF  = 32;

    // Largest frame size the design supports; sets the width of a frame length.
    localparam int FRAME_BYTES_MAX = 64;
    localparam int FCNT_W          = $clog2(FRAME_BYTES_MAX + 1);

    // Register reset values.
    localparam logic [15:0] MAGIC_RESET   = 16'h5346;
    localparam logic [4:0]  MAXPAY_RESET  = 5'd20;

    // Header offsets of the little-endian payload length.
    localparam int LEN_LO_OFS = 6;
    localparam int LEN_HI_OFS = 7;

    // Register indexes, taken from address bit 2.
    localparam logic REG_MAGIC  = 1'b0;
    localparam logic REG_MAXPAY = 1'b1;

    // Receive phase.
    typedef enum logic [1:0] {
        PH_HUNT_LO  = 2'd0,
        PH_HUNT_HI  = 2'd1,
        PH_HEADER   = 2'd2,
        PH_PAYLOAD  = 2'd3
    } phase_t;

    // Request to send one stored frame.
    typedef struct packed {
        logic              start;
        logic [FCNT_W-1:0] count;
    } emit_req_t;

endpackage

// File: hdl/mlfd_store.sv
// Frame store: one write port and one read port with registered read data.
module mlfd_store #(
    parameter int FRAME_BYTES = mlfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [$clog2(FRAME_BYTES)-1:0] waddr,
    input  logic [7:0]                     wdata,
    input  logic                           re,
    input  logic [$clog2(FRAME_BYTES)-1:0] raddr,
    output logic [7:0]                     rdata
);

    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/mlfd_ctrl.sv
// Receive control: sync word hunt, header and payload collection, store writes.
module mlfd_ctrl #(
    parameter int HEADER_BYTES = mlfd_pkg::HEADER_BYTES_DEF,
    parameter int FRAME_BYTES  = mlfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [7:0]                     rx_byte,
    input  logic [15:0]                    magic_word,
    input  logic [4:0]                     max_payload,
    output logic                           we,
    output logic [$clog2(FRAME_BYTES)-1:0] waddr,
    output logic [7:0]                     wdata,
    output mlfd_pkg::emit_req_t            emit_req
);

    localparam int AW      = $clog2(FRAME_BYTES);
    localparam int CW      = $clog2(FRAME_BYTES + 1);
    localparam int PAY_MAX = FRAME_BYTES - HEADER_BYTES;

    mlfd_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    held_reg, held_next;
    logic [CW-1:0]    need_reg, need_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [7:0]       len_hi_reg, len_hi_next;

    logic [7:0]  lo_byte, hi_byte;
    logic [15:0] len;
    logic        last_byte;
    logic        too_big;
    logic        len_zero;

    assign lo_byte   = magic_word[7:0];
    assign hi_byte   = magic_word[15:8];
    assign last_byte = (need_reg == CW'(1));
    // With an eight-byte header the high length byte is the one arriving now.
    assign len       = {(held_reg == CW'(mlfd_pkg::LEN_HI_OFS)) ? rx_byte : len_hi_reg,
                        len_lo_reg};
    assign too_big   = (len > {11'd0, max_payload}) || (len > 16'(PAY_MAX));
    assign len_zero  = (len == 16'd0);

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                mlfd_pkg::PH_HUNT_LO: begin
                    if (rx_byte == lo_byte) begin
                        phase_next = mlfd_pkg::PH_HUNT_HI;
                    end
                end
                mlfd_pkg::PH_HUNT_HI: begin
                    if (rx_byte == hi_byte) begin
                        phase_next = mlfd_pkg::PH_HEADER;
                    end else if (rx_byte != lo_byte) begin
                        phase_next = mlfd_pkg::PH_HUNT_LO;
                    end
                end
                mlfd_pkg::PH_HEADER: begin
                    if (last_byte) begin
                        phase_next = (too_big || len_zero) ? mlfd_pkg::PH_HUNT_LO
                                                           : mlfd_pkg::PH_PAYLOAD;
                    end
                end
                mlfd_pkg::PH_PAYLOAD: begin
                    if (last_byte) begin
                        phase_next = mlfd_pkg::PH_HUNT_LO;
                    end
                end
                default: begin
                    phase_next = mlfd_pkg::PH_HUNT_LO;
                end
            endcase
        end
    end

    always_comb begin
        held_next      = held_reg;
        need_next      = need_reg;
        len_lo_next    = len_lo_reg;
        len_hi_next    = len_hi_reg;
        we             = 1'b0;
        waddr          = held_reg[AW-1:0];
        wdata          = rx_byte;
        emit_req.start = 1'b0;
        emit_req.count = mlfd_pkg::FCNT_W'(held_reg + CW'(1));
        if (accept) begin
            case (phase_reg)
                mlfd_pkg::PH_HUNT_LO: begin
                    if (rx_byte == lo_byte) begin
                        we        = 1'b1;
                        waddr     = '0;
                        held_next = CW'(1);
                    end
                end
                mlfd_pkg::PH_HUNT_HI: begin
                    if (rx_byte == hi_byte) begin
                        we        = 1'b1;
                        waddr     = AW'(1);
                        held_next = CW'(2);
                        need_next = CW'(HEADER_BYTES - 2);
                    end else if (rx_byte == lo_byte) begin
                        we        = 1'b1;
                        waddr     = '0;
                        held_next = CW'(1);
                    end else begin
                        held_next = '0;
                        need_next = '0;
                    end
                end
                mlfd_pkg::PH_HEADER: begin
                    we        = 1'b1;
                    held_next = held_reg + CW'(1);
                    need_next = need_reg - CW'(1);
                    if (held_reg == CW'(mlfd_pkg::LEN_LO_OFS)) begin
                        len_lo_next = rx_byte;
                    end
                    if (held_reg == CW'(mlfd_pkg::LEN_HI_OFS)) begin
                        len_hi_next = rx_byte;
                    end
                    if (last_byte) begin
                        if (too_big || len_zero) begin
                            emit_req.start = !too_big;
                            held_next      = '0;
                            need_next      = '0;
                        end else begin
                            need_next = CW'(len);
                        end
                    end
                end
                mlfd_pkg::PH_PAYLOAD: begin
                    we        = 1'b1;
                    held_next = held_reg + CW'(1);
                    need_next = need_reg - CW'(1);
                    if (last_byte) begin
                        emit_req.start = 1'b1;
                        held_next      = '0;
                        need_next      = '0;
                    end
                end
                default: begin
                    held_next = '0;
                    need_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mlfd_pkg::PH_HUNT_LO;
            held_reg  <= '0;
            need_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            need_reg  <= need_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_lo_reg <= len_lo_next;
        len_hi_reg <= len_hi_next;
    end

endmodule

// File: hdl/mlfd_emit.sv
// Frame output sequencer: reads the store in order and drives the result register.
module mlfd_emit #(
    parameter int FRAME_BYTES = mlfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mlfd_pkg::emit_req_t            emit_req,
    output logic                           busy,
    output logic                           re,
    output logic [$clog2(FRAME_BYTES)-1:0] raddr,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [4:0]                     m_byte_index,
    output logic                           m_frame_last
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic          active_reg, active_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          valid_reg, valid_next;
    logic [4:0]    index_reg, index_next;
    logic          last_reg, last_next;
    logic          final_rd;

    assign re       = active_reg && (!valid_reg || m_ready);
    assign raddr    = idx_reg[AW-1:0];
    assign final_rd = (idx_reg + CW'(1) == count_reg);

    always_comb begin
        active_next = active_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        valid_next  = valid_reg && !m_ready;
        index_next  = index_reg;
        last_next   = last_reg;
        if (emit_req.start) begin
            active_next = 1'b1;
            idx_next    = '0;
            count_next  = CW'(emit_req.count);
        end
        if (re) begin
            valid_next = 1'b1;
            index_next = 5'(idx_reg);
            last_next  = final_rd;
            idx_next   = idx_reg + CW'(1);
            if (final_rd) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        count_reg <= count_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign busy         = active_reg;
    assign m_valid      = valid_reg;
    assign m_byte_index = index_reg;
    assign m_frame_last = last_reg;

endmodule

// File: hdl/magic_length_frame_deframer.sv
// Top level of the magic-length frame deframer with its APB register block.
// Readout: frame completion sets the sequencer busy; it then reads the first byte out.
// Throughput: one input byte per cycle while collecting; a completed frame is read out
// of the store at one byte per cycle while the receiver does not stall, and no input
// transfer is taken until its last byte has been read.
// Reset: synchronous, active low; control state clears, the frame store does not.
module magic_length_frame_deframer #(
    parameter int HEADER_BYTES = mlfd_pkg::HEADER_BYTES_DEF,
    parameter int FRAME_BYTES  = mlfd_pkg::FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // Frame byte channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic [4:0]  m_byte_index,
    output logic        m_frame_last,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(FRAME_BYTES);

    // Configuration registers. A write lands on the access cycle of an APB transfer;
    // the register is chosen by address bit 2 alone.
    logic [15:0] magic_reg, magic_next;
    logic [4:0]  max_payload_reg, max_payload_next;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        magic_next       = magic_reg;
        max_payload_next = max_payload_reg;
        if (cfg_wr) begin
            case (paddr[2])
                mlfd_pkg::REG_MAGIC:  magic_next       = pwdata[15:0];
                mlfd_pkg::REG_MAXPAY: max_payload_next = pwdata[4:0];
                default:              magic_next       = magic_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mlfd_pkg::REG_MAGIC:  prdata = {16'd0, magic_reg};
            mlfd_pkg::REG_MAXPAY: prdata = {27'd0, max_payload_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg       <= mlfd_pkg::MAGIC_RESET;
            max_payload_reg <= mlfd_pkg::MAXPAY_RESET;
        end else begin
            magic_reg       <= magic_next;
            max_payload_reg <= max_payload_next;
        end
    end

    // Input transfers are held off only while a stored frame is being read out.
    // The last frame byte may still sit in the output register while the next
    // input transfer is taken, since it no longer needs the store.
    logic                busy;
    logic                accept;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    mlfd_pkg::emit_req_t emit_req;

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    // The receive control writes each kept byte into the store at its frame offset
    // and asks for readout once the header and an announced payload within bounds are complete.
    mlfd_ctrl #(
        .HEADER_BYTES (HEADER_BYTES),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .magic_word  (magic_reg),
        .max_payload (max_payload_reg),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .emit_req    (emit_req)
    );

    // The store's read data register doubles as the frame byte output register.
    mlfd_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (m_frame_byte)
    );

    // The sequencer issues a read whenever the output register is free or is being
    // emptied in the same cycle, so a frame streams out at one byte per cycle while the receiver does not stall.
    mlfd_emit #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .emit_req     (emit_req),
        .busy         (busy),
        .re           (re),
        .raddr        (raddr),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_byte_index (m_byte_index),
        .m_frame_last (m_frame_last)
    );

    // The store is never written and read in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(we && re))
        else $error("frame store written during readout");

    // A completed frame stops input transfers in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) emit_req.start |=> !s_ready)
        else $error("input not held off after frame completion");

    // The transfer after the last byte of a frame starts a new frame at offset zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_frame_last) |=> (!m_valid || m_byte_index == 5'd0))
        else $error("frame readout did not restart at offset zero");

    // A readout request never arrives while a readout is still running.
    assert property (@(posedge aclk) disable iff (!aresetn) emit_req.start |-> !busy)
        else $error("frame completed during readout");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the magic-length frame deframer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_LEN     = mlfd_pkg::HEADER_BYTES_DEF;
    localparam int FRM_LEN     = mlfd_pkg::FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_DIRECTED  = 29;
    localparam int N_SETTINGS  = 5;

    // One byte of an emitted frame, as the result channel shows it.
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] index;
        logic       last;
    } frame_beat_t;

    // One row of the directed sequence. Where 'known' is set, 'beats' is the
    // number of frame bytes this input byte must release, read straight off
    // the frame format; otherwise the predictor alone decides.
    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        logic [5:0] beats;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_frame_byte;
    logic [4:0]  m_byte_index;
    logic        m_frame_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Frame bytes the deframer owes us, oldest first.
    frame_beat_t frame_bytes_due [$];
    int          mismatches  = 0;
    int          beats_seen  = 0;
    int          cycle_count = 0;
    // When set, neither side idles; this gives stretches of back-to-back traffic.
    logic        steady      = 1'b0;

    // Our own copy of the deframer: register values and receive state.
    logic [15:0]        sync_word;
    logic [4:0]         max_len;
    mlfd_pkg::phase_t   rx_state;
    logic [7:0]         held_frame [FRM_LEN];
    int                 held_count;
    int                 still_needed;
    int                 accepted_len;

    // The directed sequence runs with the reset values: sync word 0x5346,
    // so 0x46 is the low byte and 0x53 the high byte, and 20 payload bytes max.
    directed_row_t directed_rows [N_DIRECTED] = '{
        // Line noise straight after reset never starts a frame.
        '{8'h00, 1'b1, 6'd0}, '{8'hFF, 1'b1, 6'd0},
        // A low byte, the low byte again (the hunt restarts on it), then the high byte.
        '{8'h46, 1'b0, 6'd0}, '{8'h46, 1'b0, 6'd0}, '{8'h53, 1'b0, 6'd0},
        // Header bytes 2 to 5, then a zero length at offsets 6 and 7.
        '{8'h00, 1'b0, 6'd0}, '{8'hFF, 1'b0, 6'd0}, '{8'hAA, 1'b0, 6'd0},
        '{8'h55, 1'b0, 6'd0}, '{8'h00, 1'b0, 6'd0}, '{8'h00, 1'b0, 6'd0},
        // The rest of the header; an empty payload releases all 12 bytes at once.
        '{8'h01, 1'b0, 6'd0}, '{8'h80, 1'b0, 6'd0}, '{8'h7F, 1'b0, 6'd0},
        '{8'hFE, 1'b1, 6'd12},
        // A low byte followed by a stranger sends the hunt back to the start.
        '{8'h46, 1'b0, 6'd0}, '{8'h00, 1'b1, 6'd0},
        // A frame with length 0xFFFF is dropped without any output.
        '{8'h46, 1'b0, 6'd0}, '{8'h53, 1'b0, 6'd0},
        '{8'h11, 1'b0, 6'd0}, '{8'h22, 1'b0, 6'd0}, '{8'h33, 1'b0, 6'd0},
        '{8'h44, 1'b0, 6'd0}, '{8'hFF, 1'b0, 6'd0}, '{8'hFF, 1'b0, 6'd0},
        '{8'h01, 1'b0, 6'd0}, '{8'h02, 1'b0, 6'd0}, '{8'h04, 1'b0, 6'd0},
        '{8'h08, 1'b1, 6'd0}
    };

    magic_length_frame_deframer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_byte_index (m_byte_index),
        .m_frame_last (m_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #2 aclk = ~aclk;

    // Idle lengths: mostly none, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drop whatever frame was in progress and hunt for the low sync byte again.
    function automatic void restart_hunt();
        rx_state     = mlfd_pkg::PH_HUNT_LO;
        held_count   = 0;
        still_needed = 0;
        accepted_len = 0;
    endfunction

    function automatic void hold_byte(logic [7:0] b);
        if (held_count < FRM_LEN) held_frame[held_count] = b;
        held_count++;
        if (still_needed > 0) still_needed--;
    endfunction

    // Queue every held byte as an expected transfer and go back to hunting.
    function automatic int release_frame();
        int n;
        n = (held_count > FRM_LEN) ? FRM_LEN : held_count;
        for (int i = 0; i < n; i++) begin
            frame_bytes_due.push_back('{held_frame[i], 5'(i), i == n - 1});
        end
        restart_hunt();
        return n;
    endfunction

    // Advances the receive state by one accepted byte and returns how many
    // frame bytes that byte releases.
    function automatic int deframe_byte(logic [7:0] b);
        int len;
        case (rx_state)
            mlfd_pkg::PH_HUNT_LO: begin
                if (b == sync_word[7:0]) begin
                    held_frame[0] = b;
                    held_count    = 1;
                    rx_state      = mlfd_pkg::PH_HUNT_HI;
                end
                return 0;
            end
            mlfd_pkg::PH_HUNT_HI: begin
                // The high byte wins when both halves of the sync word are equal.
                if (b == sync_word[15:8]) begin
                    held_frame[1] = b;
                    held_count    = 2;
                    still_needed  = HDR_LEN - 2;
                    rx_state      = mlfd_pkg::PH_HEADER;
                end else if (b == sync_word[7:0]) begin
                    held_frame[0] = b;
                    held_count    = 1;
                end else begin
                    restart_hunt();
                end
                return 0;
            end
            mlfd_pkg::PH_HEADER: begin
                hold_byte(b);
                if (still_needed != 0) return 0;
                len = int'({held_frame[mlfd_pkg::LEN_HI_OFS],
                            held_frame[mlfd_pkg::LEN_LO_OFS]});
                if (len > max_len || len > FRM_LEN - HDR_LEN) begin
                    restart_hunt();
                    return 0;
                end
                accepted_len = len;
                if (len == 0) return release_frame();
                still_needed = len;
                rx_state     = mlfd_pkg::PH_PAYLOAD;
                return 0;
            end
            default: begin
                hold_byte(b);
                if (still_needed != 0) return 0;
                return release_frame();
            end
        endcase
    endfunction

    // Offers one byte, optionally after an idle gap, and waits for the
    // transfer. Called and returning at a falling edge, so a byte that
    // follows without a gap keeps valid high with only one update.
    task automatic push_byte(input logic [7:0] b, output int released);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        released = deframe_byte(b);
        @(negedge aclk);
    endtask

    // Feeds filler until the deframer is back in the low-byte hunt, so a
    // register change never lands in the middle of a frame.
    task automatic flush_to_hunt();
        logic [7:0] filler;
        int         n;
        while (rx_state != mlfd_pkg::PH_HUNT_LO) begin
            filler = 8'($urandom_range(0, 255));
            if (rx_state == mlfd_pkg::PH_HUNT_HI) begin
                while (filler == sync_word[7:0] || filler == sync_word[15:8])
                    filler = 8'($urandom_range(0, 255));
            end
            push_byte(filler, n);
        end
    endtask

    // Sends one frame with random content. Most lengths are accepted, with
    // the largest and the empty payload favored; some are too long and the
    // frame is dropped after its header.
    task automatic send_frame(output int sent);
        int         lim;
        int         len;
        int         r;
        int         n;
        logic [7:0] b;
        lim = (max_len < 20) ? int'(max_len) : 20;
        r   = $urandom_range(0, 99);
        if (r < 12) begin
            if ($urandom_range(0, 1) == 1) len = $urandom_range(lim + 1, 31);
            else len = $urandom_range(32, 65535);
        end else if (r < 27) begin
            len = 0;
        end else if (r < 50) begin
            len = lim;
        end else begin
            len = $urandom_range(0, lim);
        end
        push_byte(sync_word[7:0], n);
        push_byte(sync_word[15:8], n);
        for (int i = 2; i < HDR_LEN; i++) begin
            if (i == mlfd_pkg::LEN_LO_OFS) b = 8'(len);
            else if (i == mlfd_pkg::LEN_HI_OFS) b = 8'(len >> 8);
            else b = 8'($urandom_range(0, 255));
            push_byte(b, n);
        end
        sent = HDR_LEN;
        if (len <= lim) begin
            for (int i = 0; i < len; i++) begin
                push_byte(8'($urandom_range(0, 255)), n);
            end
            sent += len;
        end
    endtask

    // Random traffic: mostly whole frames, the rest plain line noise and
    // sync words that break off early. Only frame bytes count toward the budget.
    task automatic run_traffic(input int budget);
        int sent;
        int r;
        int n;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                flush_to_hunt();
                send_frame(n);
                sent += n;
            end else if (r < 85) begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), n);
            end else begin
                push_byte(sync_word[7:0], n);
                if ($urandom_range(0, 1) == 1) push_byte(sync_word[7:0], n);
                push_byte(8'($urandom_range(0, 255)), n);
            end
        end
        flush_to_hunt();
    endtask

    // Writes one register through the APB port, then reads it back. The
    // task starts on a falling edge and returns on one.
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        logic [31:0] mask;
        mask = (reg_sel == mlfd_pkg::REG_MAGIC) ? 32'h0000_FFFF : 32'h0000_001F;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == mlfd_pkg::REG_MAGIC) sync_word = value[15:0];
        else max_len = value[4:0];
        // Straight into the setup cycle of the read-back.
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register at %0h reads back: expected %08h, got %08h",
                     $time, paddr, value & mask, prdata & mask);
            mismatches++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until every expected frame byte has come out, then lets the
    // deframer settle on any trailing byte that released nothing.
    task automatic drain_frames();
        while (frame_bytes_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Compare each frame-byte transfer with the oldest expectation.
    always @(posedge aclk) begin : check_frames
        frame_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: unexpected frame byte: expected none, got %02h index %0d last %0b",
                         $time, m_frame_byte, m_byte_index, m_frame_last);
                mismatches++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_frame_byte !== want.data) begin
                    $display("%0t: frame byte at index %0d: expected %02h, got %02h",
                             $time, want.index, want.data, m_frame_byte);
                    mismatches++;
                end
                if (m_byte_index !== want.index) begin
                    $display("%0t: byte index: expected %0d, got %0d",
                             $time, want.index, m_byte_index);
                    mismatches++;
                end
                if (m_frame_last !== want.last) begin
                    $display("%0t: last flag at index %0d: expected %0b, got %0b",
                             $time, want.index, want.last, m_frame_last);
                    mismatches++;
                end
            end
        end
    end

    // The frame receiver. It stalls at random, and once, after some traffic
    // has gone by, it holds off for a long stretch so the deframer fills up
    // and stops taking input bytes while the sender keeps offering them.
    initial begin : frame_receiver
        int  stall_left;
        int  hold_left;
        logic pressure_done;
        stall_left    = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        m_ready       = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (!pressure_done && beats_seen >= 60) begin
                pressure_done = 1'b1;
                hold_left     = 399;
                m_ready       = 1'b0;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                m_ready    = (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Guard against a hang: no correct run comes near this many cycles.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] setting_sync [N_SETTINGS];
        logic [4:0]  setting_len  [N_SETTINGS];
        logic        setting_fast [N_SETTINGS];
        int          n;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        sync_word = mlfd_pkg::MAGIC_RESET;
        max_len   = mlfd_pkg::MAXPAY_RESET;
        restart_hunt();

        // Register settings after the reset phase: both extremes of each
        // register, a sync word whose halves are equal, one random setting,
        // and the reset values written back explicitly. The second setting
        // runs without any idling on either side.
        setting_sync = '{16'h0000, 16'hFFFF, 16'hA5A5, 16'h0000, mlfd_pkg::MAGIC_RESET};
        setting_len  = '{5'd31, 5'd0, 5'd12, 5'd0, mlfd_pkg::MAXPAY_RESET};
        setting_fast = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        setting_sync[3] = 16'($urandom_range(0, 65535));
        setting_len[3]  = 5'($urandom_range(0, 31));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed bytes first, under the reset register values.
        foreach (directed_rows[i]) begin
            push_byte(directed_rows[i].rx, n);
            if (directed_rows[i].known && n != directed_rows[i].beats) begin
                $display("%0t: directed byte %0d releases %0d frame bytes, expected %0d",
                         $time, i, n, directed_rows[i].beats);
                mismatches++;
            end
        end
        run_traffic(20);
        s_valid = 1'b0;

        for (int p = 0; p < N_SETTINGS; p++) begin
            drain_frames();
            write_register(mlfd_pkg::REG_MAGIC, {16'h0000, setting_sync[p]});
            write_register(mlfd_pkg::REG_MAXPAY, {27'd0, setting_len[p]});
            steady = setting_fast[p];
            run_traffic(30);
            s_valid = 1'b0;
            steady  = 1'b0;
        end

        drain_frames();
        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
